// ===== rtl/core/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion block
// no dependencies

package rmq_pkg;

	localparam int FIELD_W = 18;
	localparam int DIFF_W = 19;
	localparam int TRACE_W = 20;
	localparam int DEF_FRAC_BITS = 16;
	localparam int QUOT_BITS = 19;

	typedef struct packed {
		logic degen;
		logic signed [TRACE_W-1:0] tr;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
	} rmq_item_t;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// rotation matrix to quaternion: front, queue and sqrt/divide back end
// R = (max(FRAC_BITS, 19) + FRAC_BITS + 3) / 2 rounded down, the number of sqrt stages
// throughput: one transaction per cycle, set by the fully pipelined sqrt and divider stages
// the receiver cannot stall; busy only rises if the queue fills, which the back end prevents
// arst_n clears all valid flags; no result strobes until new transactions arrive

module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [FIELD_W-1:0] m00,
	input  logic signed [FIELD_W-1:0] m01,
	input  logic signed [FIELD_W-1:0] m02,
	input  logic signed [FIELD_W-1:0] m10,
	input  logic signed [FIELD_W-1:0] m11,
	input  logic signed [FIELD_W-1:0] m12,
	input  logic signed [FIELD_W-1:0] m20,
	input  logic signed [FIELD_W-1:0] m21,
	input  logic signed [FIELD_W-1:0] m22,
	output logic done,
	output logic signed [FIELD_W-1:0] quat_w,
	output logic signed [FIELD_W-1:0] quat_x,
	output logic signed [FIELD_W-1:0] quat_y,
	output logic signed [FIELD_W-1:0] quat_z,
	output logic degenerate
);

	logic push;
	logic q_full;
	logic pop;
	rmq_item_t f_item;
	rmq_item_t b_item;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .q_full(q_full),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.busy(busy), .push(push), .item(f_item)
	);

	rmq_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(f_item),
		.full(q_full), .pop(pop), .rd_item(b_item)
	);

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(pop), .in_item(b_item),
		.done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
		.quat_z(quat_z), .degenerate(degenerate)
	);

endmodule

// ===== rtl/core/rmq_front.sv =====
// front: accepts a transaction, forms trace and off-diagonal differences, flags degenerate
// depends on rmq_pkg

module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic q_full,
	input  logic signed [FIELD_W-1:0] m00,
	input  logic signed [FIELD_W-1:0] m01,
	input  logic signed [FIELD_W-1:0] m02,
	input  logic signed [FIELD_W-1:0] m10,
	input  logic signed [FIELD_W-1:0] m11,
	input  logic signed [FIELD_W-1:0] m12,
	input  logic signed [FIELD_W-1:0] m20,
	input  logic signed [FIELD_W-1:0] m21,
	input  logic signed [FIELD_W-1:0] m22,
	output logic busy,
	output logic push,
	output rmq_item_t item
);

	localparam int FW = ((FRAC_BITS > TRACE_W) ? FRAC_BITS : TRACE_W) + 2;

	logic valid_s1;
	rmq_item_t item_s1;
	rmq_item_t item_d;
	logic signed [FW-1:0] s_ext;

	always_comb begin
		item_d.tr = TRACE_W'(m00) + TRACE_W'(m11) + TRACE_W'(m22);
		item_d.dx = DIFF_W'(m12) - DIFF_W'(m21);
		item_d.dy = DIFF_W'(m20) - DIFF_W'(m02);
		item_d.dz = DIFF_W'(m01) - DIFF_W'(m10);
		s_ext = FW'(item_d.tr) + (FW'(1) <<< FRAC_BITS);
		item_d.degen = s_ext[FW-1] || (s_ext == '0);
	end

	assign busy = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/core/rmq_queue.sv =====
// two-entry queue between front and back
// depends on rmq_pkg

module rmq_queue import rmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rmq_item_t wr_item,
	output logic full,
	output logic pop,
	output rmq_item_t rd_item
);

	rmq_item_t mem_q [0:1];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign pop = (count_q != 2'd0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/core/rmq_back.sv =====
// back: pipelined square root, then three pipelined dividers with saturation
// depends on rmq_pkg

module rmq_back import rmq_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  rmq_item_t in_item,
	output logic done,
	output logic signed [FIELD_W-1:0] quat_w,
	output logic signed [FIELD_W-1:0] quat_x,
	output logic signed [FIELD_W-1:0] quat_y,
	output logic signed [FIELD_W-1:0] quat_z,
	output logic degenerate
);

	localparam int SW = ((FRAC_BITS > TRACE_W - 1) ? FRAC_BITS : TRACE_W - 1) + 2;
	localparam int RW = 2 * ((SW + FRAC_BITS + 1) / 2);
	localparam int RB = RW / 2;
	localparam int NW = DIFF_W + FRAC_BITS;
	localparam int CW = NW + 22;
	localparam int DW = FIELD_W + 2;
	localparam int QB = QUOT_BITS;

	// square root stages
	logic sq_v_s [0:RB];
	logic sq_deg_s [0:RB];
	logic [RW-1:0] sq_rem_s [0:RB];
	logic [RB-1:0] sq_root_s [0:RB];
	logic signed [DIFF_W-1:0] sq_d_s [0:RB][0:2];

	logic signed [SW:0] s_full;
	assign s_full = (SW+1)'(in_item.tr) + ((SW+1)'(1) <<< FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else sq_v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		sq_deg_s[0] <= in_item.degen;
		sq_rem_s[0] <= in_item.degen ? '0 : (RW'(s_full[SW-1:0]) << FRAC_BITS);
		sq_root_s[0] <= '0;
		sq_d_s[0][0] <= in_item.dx;
		sq_d_s[0][1] <= in_item.dy;
		sq_d_s[0][2] <= in_item.dz;
	end

	for (genvar k = 0; k < RB; k++) begin : g_sq
		localparam int BI = RB - 1 - k;
		logic [RW:0] trial;
		logic take;
		assign trial = ((RW+1)'(sq_root_s[k]) << (BI + 1)) + ((RW+1)'(1) << (2 * BI));
		assign take = ((RW+1)'(sq_rem_s[k]) >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			sq_deg_s[k+1] <= sq_deg_s[k];
			sq_rem_s[k+1] <= take ? RW'((RW+1)'(sq_rem_s[k]) - trial) : sq_rem_s[k];
			sq_root_s[k+1] <= take ? (sq_root_s[k] | (RB'(1) << BI)) : sq_root_s[k];
			sq_d_s[k+1] <= sq_d_s[k];
		end
	end

	// w stage: halve, saturate, form divisor and magnitudes
	logic w_v_q;
	logic w_deg_q;
	logic [FIELD_W-2:0] w_q;
	logic [NW-1:0] w_num_q [0:2];
	logic w_neg_q [0:2];
	logic [RB-1:0] half_root;
	logic [FIELD_W-2:0] w_sat;

	assign half_root = sq_root_s[RB] >> 1;
	assign w_sat = (half_root > RB'({(FIELD_W-1){1'b1}})) ?
		{(FIELD_W-1){1'b1}} : (FIELD_W-1)'(half_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) w_v_q <= 1'b0;
		else w_v_q <= sq_v_s[RB];
	end

	for (genvar l = 0; l < 3; l++) begin : g_mag
		logic [DIFF_W-1:0] mag;
		assign mag = sq_d_s[RB][l][DIFF_W-1] ? DIFF_W'(-sq_d_s[RB][l]) : DIFF_W'(sq_d_s[RB][l]);
		always_ff @(posedge clk) begin
			w_num_q[l] <= NW'(mag) << FRAC_BITS;
			w_neg_q[l] <= sq_d_s[RB][l][DIFF_W-1];
		end
	end

	always_ff @(posedge clk) begin
		w_deg_q <= sq_deg_s[RB];
		w_q <= w_sat;
	end

	// divider stages, overflow check first
	logic dv_v_s [0:QB];
	logic dv_deg_s [0:QB];
	logic [FIELD_W-2:0] dv_w_s [0:QB];
	logic [NW-1:0] dv_rem_s [0:QB][0:2];
	logic [QB-1:0] dv_q_s [0:QB][0:2];
	logic dv_ovf_s [0:QB][0:2];
	logic dv_neg_s [0:QB][0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else dv_v_s[0] <= w_v_q;
	end

	always_ff @(posedge clk) begin
		dv_deg_s[0] <= w_deg_q;
		dv_w_s[0] <= w_q;
	end

	for (genvar l = 0; l < 3; l++) begin : g_ovf
		always_ff @(posedge clk) begin
			dv_rem_s[0][l] <= w_num_q[l];
			dv_q_s[0][l] <= '0;
			dv_neg_s[0][l] <= w_neg_q[l];
			dv_ovf_s[0][l] <= (CW'(w_num_q[l]) >= (CW'(w_q) << (QB + 2)));
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_dv
		localparam int BI = QB - 1 - j;
		logic [CW-1:0] dsh;
		assign dsh = CW'(dv_w_s[j]) << (BI + 2);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			dv_deg_s[j+1] <= dv_deg_s[j];
			dv_w_s[j+1] <= dv_w_s[j];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic take;
			assign take = (CW'(dv_rem_s[j][l]) >= dsh);
			always_ff @(posedge clk) begin
				dv_rem_s[j+1][l] <= take ? NW'(CW'(dv_rem_s[j][l]) - dsh) : dv_rem_s[j][l];
				dv_q_s[j+1][l] <= take ? (dv_q_s[j][l] | (QB'(1) << BI)) : dv_q_s[j][l];
				dv_ovf_s[j+1][l] <= dv_ovf_s[j][l];
				dv_neg_s[j+1][l] <= dv_neg_s[j][l];
			end
		end
	end

	// saturate and register the result
	logic signed [FIELD_W-1:0] res [0:2];
	for (genvar l = 0; l < 3; l++) begin : g_sat
		logic [QB-1:0] qv;
		always_comb begin
			qv = dv_ovf_s[QB][l] ? {QB{1'b1}} : dv_q_s[QB][l];
			if (dv_neg_s[QB][l]) begin
				res[l] = (qv >= (QB'(1) << (FIELD_W - 1))) ?
					{1'b1, {(FIELD_W-1){1'b0}}} : FIELD_W'(-qv);
			end else begin
				res[l] = (qv >= (QB'(1) << (FIELD_W - 1))) ?
					{1'b0, {(FIELD_W-1){1'b1}}} : FIELD_W'(qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv_v_s[QB];
	end

	always_ff @(posedge clk) begin
		degenerate <= dv_deg_s[QB];
		quat_w <= dv_deg_s[QB] ? '0 : FIELD_W'(dv_w_s[QB]);
		quat_x <= dv_deg_s[QB] ? '0 : res[0];
		quat_y <= dv_deg_s[QB] ? '0 : res[1];
		quat_z <= dv_deg_s[QB] ? '0 : res[2];
	end

endmodule

// ===== rtl/core/rmq_checker.sv =====
// port-level checks for the rotation matrix to quaternion block, bound to the top level
// depends on rmq_pkg and rotation_matrix_to_quaternion_top

module rmq_checker import rmq_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [FIELD_W-1:0] quat_w,
	input logic signed [FIELD_W-1:0] quat_x,
	input logic signed [FIELD_W-1:0] quat_y,
	input logic signed [FIELD_W-1:0] quat_z,
	input logic degenerate
);

	localparam int SW = ((FRAC_BITS > TRACE_W - 1) ? FRAC_BITS : TRACE_W - 1) + 2;
	localparam int RB = (SW + FRAC_BITS + 1) / 2;
	localparam int LAT = RB + 25;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("transaction result missing at expected latency");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although back end never stalls");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0)
		else $error("degenerate result not zeroed");

	a_w_positive: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> !quat_w[FIELD_W-1] && quat_w != '0)
		else $error("scalar part not positive");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
	.degenerate(degenerate)
);

// ===== test/rmq_checker.sv =====
// checker for the rotation matrix to quaternion block: predicts and compares results
// depends on rmq_pkg

module rmq_tb_checker import rmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	input  logic done,
	input  logic signed [FIELD_W-1:0] quat_w, quat_x, quat_y, quat_z,
	input  logic degenerate,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic signed [FIELD_W-1:0] w;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
		logic degen;
	} quat_t;

	quat_t quat_q[$];

	function automatic longint clamp18(input longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967295;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint scaled_div(input longint num, input longint den);
		longint mag, q;
		mag = num < 0 ? -num : num;
		q = (mag <<< DEF_FRAC_BITS) / den;
		return clamp18(num < 0 ? -q : q);
	endfunction

	function automatic quat_t matrix_to_quat(input longint a00, a01, a02, a10, a11, a12,
		a20, a21, a22);
		quat_t r;
		longint s, w, den;
		s = (longint'(1) <<< DEF_FRAC_BITS) + a00 + a11 + a22;
		r = '0;
		if (s <= 0) begin
			r.degen = 1'b1;
			return r;
		end
		w = clamp18(int_sqrt(s <<< DEF_FRAC_BITS) >>> 1);
		den = 4 * w;
		r.w = w[FIELD_W-1:0];
		r.x = FIELD_W'(scaled_div(a12 - a21, den));
		r.y = FIELD_W'(scaled_div(a20 - a02, den));
		r.z = FIELD_W'(scaled_div(a01 - a10, den));
		return r;
	endfunction

	assign pending = quat_q.size();

	initial errors = 0;

	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n) begin
			if (start && !busy)
				quat_q = {quat_q, matrix_to_quat(m00, m01, m02, m10, m11, m12, m20, m21, m22)};
			if (done) begin
				if (quat_q.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					exp_q = quat_q.pop_front();
					if (quat_w !== exp_q.w) begin
						$error("quat_w expected %0d actual %0d", exp_q.w, quat_w);
						errors++;
					end
					if (quat_x !== exp_q.x) begin
						$error("quat_x expected %0d actual %0d", exp_q.x, quat_x);
						errors++;
					end
					if (quat_y !== exp_q.y) begin
						$error("quat_y expected %0d actual %0d", exp_q.y, quat_y);
						errors++;
					end
					if (quat_z !== exp_q.z) begin
						$error("quat_z expected %0d actual %0d", exp_q.z, quat_z);
						errors++;
					end
					if (degenerate !== exp_q.degen) begin
						$error("degenerate expected %0d actual %0d", exp_q.degen, degenerate);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ===== test/tb_rotation_matrix_to_quaternion_top.sv =====
// testbench top for rotation_matrix_to_quaternion_top: directed and random matrices, random gaps
// depends on rmq_pkg, rmq_tb_checker and the block's rtl

module tb_rotation_matrix_to_quaternion_top;
	import rmq_pkg::*;

	localparam int LATENCY = 40;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic done;
	logic signed [FIELD_W-1:0] quat_w, quat_x, quat_y, quat_z;
	logic degenerate;
	int errors;
	int pending;
	int idle_pct;

	rotation_matrix_to_quaternion_top dut (.*);

	rmq_tb_checker chk (.*);

	initial clk = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [FIELD_W-1:0] rand_elem(input int sel);
		case (sel)
			0: return 18'h1FFFF;
			1: return 18'h20000;
			2: return 18'h10000;
			3: return 18'h30000;
			4: return 18'h0;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	// one transaction: gap, then hold start until accepted
	task automatic send(input logic [FIELD_W-1:0] a00, a01, a02, a10, a11, a12,
		a20, a21, a22);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} =
			{a00, a01, a02, a10, a11, a12, a20, a21, a22};
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 1'b0;
	endtask

	// rotation about one axis with random angle-like content
	task automatic send_rotation();
		int c, s, ax;
		logic [FIELD_W-1:0] cv, sv, nsv;
		c = $urandom_range(131071) - 65536;
		s = $urandom_range(131071) - 65536;
		ax = $urandom_range(2);
		if ($urandom_range(3) == 0) begin
			c = $urandom_range(65536);
			s = $urandom_range(65536);
		end
		cv = FIELD_W'(c);
		sv = FIELD_W'(s);
		nsv = FIELD_W'(-s);
		case (ax)
			0: send(18'h10000, '0, '0, '0, cv, nsv, '0, sv, cv);
			1: send(cv, '0, sv, '0, 18'h10000, '0, nsv, '0, cv);
			default: send(cv, nsv, '0, sv, cv, '0, '0, '0, 18'h10000);
		endcase
	endtask

	task automatic send_random();
		send(rand_elem($urandom_range(12)), rand_elem($urandom_range(12)),
			rand_elem($urandom_range(12)), rand_elem($urandom_range(12)),
			rand_elem($urandom_range(12)), rand_elem($urandom_range(12)),
			rand_elem($urandom_range(12)), rand_elem($urandom_range(12)),
			rand_elem($urandom_range(12)));
	endtask

	initial begin
		start = 1'b0;
		idle_pct = 0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// identity, extremes, degenerate boundary and saturating quotients
		send(18'h10000, '0, '0, '0, 18'h10000, '0, '0, '0, 18'h10000);
		send('0, '0, '0, '0, '0, '0, '0, '0, '0);
		send(18'h30000, '0, '0, '0, '0, '0, '0, '0, '0);
		send(18'h30001, '0, '0, '0, '0, '0, '0, '0, '0);
		send(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
			18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
		send(18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000,
			18'h20000, 18'h20000, 18'h20000);
		send(18'h30000, 18'h1FFFF, 18'h20000, 18'h20000, '0, 18'h1FFFF, 18'h1FFFF,
			18'h20000, 18'h1);
		send(18'h30000, 18'h20000, 18'h1FFFF, 18'h1FFFF, '0, 18'h20000, 18'h20000,
			18'h1FFFF, 18'h1);
		send(18'h10000, '0, '0, '0, 18'h30000, '0, '0, '0, 18'h30000);
		send(18'h10000, '0, '0, '0, 18'h30000, 18'h1, '0, '0, 18'h30000);
		send(18'h1FFFF, '0, '0, '0, 18'h1FFFF, '0, '0, '0, 18'h1FFFF);
		send('0, 18'h2AAAA, 18'h15555, 18'h15555, '0, 18'h2AAAA, 18'h2AAAA, 18'h15555, '0);
		while (pending != 0) @(negedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 46 : (ph == 3) ? 11 : 0;
			for (int i = 0; i < 160; i++) begin
				if ($urandom_range(9) < 6) send_rotation();
				else send_random();
			end
			// long pause until everything outstanding has returned
			while (pending != 0) @(negedge clk);
		end
		repeat (LATENCY) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("** rotation_matrix_to_quaternion_top: PASSED **");
		else
			$display("** rotation_matrix_to_quaternion_top: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** rotation_matrix_to_quaternion_top: FAILED **");
		$finish;
	end

endmodule
